// File: design/pcas_pkg.sv
`default_nettype none
package pcas_pkg;

    localparam int DIV_W      = 24;
    localparam int DVS_W      = 17;
    localparam int DIV_CNT_W  = $clog2(DIV_W);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    localparam logic       CMD_START    = 1'b0;
    localparam logic       CMD_FRAME    = 1'b1;

    localparam logic [1:0] KIND_START   = 2'd0;
    localparam logic [1:0] KIND_PORTION = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LIMIT = 1'b1;

    localparam logic [DVS_W-1:0] PAGE_SIZE_MAX = 17'd65536;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_ADDR,
        ST_WAIT_ADDR,
        ST_CHECK,
        ST_WAIT_LEN,
        ST_EMIT_START,
        ST_EMIT_ERR,
        ST_MUL,
        ST_EMIT_PORTION
    } pcas_state_t;

    typedef struct packed {
        logic capture;
        logic div_start;
        logic div_len;
        logic save_start;
        logic mul;
        logic emit_start;
        logic emit_err;
        logic emit_portion;
    } pcas_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic addr_err;
        logic multi_page;
        logic no_pages;
    } pcas_status_t;

    function automatic logic [DVS_W-1:0] eff_page_size(input logic [DVS_W-1:0] raw);
        logic [DVS_W-1:0] ps;
        ps = raw;
        if (raw == '0) begin
            ps = 17'd1;
        end else if (raw > PAGE_SIZE_MAX) begin
            ps = PAGE_SIZE_MAX;
        end
        return ps;
    endfunction

endpackage
`default_nettype wire

// File: design/pcas_div.sv
`default_nettype none
module pcas_div
    import pcas_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  busy,
    output logic [DIV_W-1:0]      quotient,
    output logic [DVS_W-1:0]      remainder
);

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DVS_W-1:0]     rem_reg, rem_next;
    logic [DVS_W-1:0]     dvs_reg, dvs_next;
    logic [DVS_W:0]       trial;
    logic [DVS_W:0]       diff;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DIV_W-2:0], fits};
            rem_next = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

// File: design/pcas_datapath.sv
`default_nettype none
module pcas_datapath
    import pcas_pkg::*;
#(
    parameter int MAX_ACCESS_BYTES = 4096
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire pcas_cmd_t             cmd,
    output pcas_status_t               status,
    input  wire logic                  cfg_write_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [23:0]           s_logical_address,
    input  wire logic [12:0]           s_access_length,
    input  wire logic [15:0]           s_frame_number,
    output logic [1:0]                 m_kind,
    output logic [15:0]                m_first_page,
    output logic [12:0]                m_pages_needed,
    output logic [12:0]                m_portion_base,
    output logic [12:0]                m_portion_length,
    output logic [31:0]                m_physical_address,
    output logic                       m_last
);

    localparam logic [16:0] MAX_LEN = 17'(MAX_ACCESS_BYTES);

    logic [16:0] page_size_reg;
    logic [15:0] page_limit_reg;

    logic [23:0] addr_reg;
    logic [12:0] len_reg, len_next;
    logic [15:0] frame_reg;

    logic [15:0] start_offset_reg;
    logic [12:0] bytes_left_reg;
    logic [12:0] data_base_reg;
    logic [12:0] pages_left_reg;
    logic        first_portion_reg;

    logic [15:0] page_reg;
    logic [15:0] off_reg;
    logic        multi_reg;
    logic [31:0] prod_reg;

    logic [1:0]  kind_reg;
    logic [15:0] first_page_reg;
    logic [12:0] pages_needed_reg;
    logic [12:0] portion_base_reg;
    logic [12:0] portion_length_reg;
    logic [31:0] phys_reg;
    logic        last_reg;

    logic [16:0] ps_eff;
    logic        div_busy;
    logic [23:0] div_quo;
    logic [16:0] div_rem;
    logic [23:0] div_dividend;
    logic [16:0] len_rem_sum;
    logic [16:0] avail;
    logic [12:0] pages;
    logic [32:0] product;
    logic [16:0] room;
    logic [16:0] plen_wide;
    logic [12:0] plen;
    logic [31:0] phys;

    assign ps_eff = eff_page_size(page_size_reg);

    assign len_next = ({4'b0, s_access_length} > MAX_LEN) ? 13'(MAX_LEN) : s_access_length;

    assign len_rem_sum  = {4'b0, len_reg} + div_rem - 17'd1;
    assign div_dividend = cmd.div_len ? {7'b0, len_rem_sum} : addr_reg;

    pcas_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (ps_eff),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign avail = ps_eff - div_rem;

    assign status.div_busy   = div_busy;
    assign status.addr_err   = div_quo > {8'b0, page_limit_reg};
    assign status.multi_page = {4'b0, len_reg} > avail;
    assign status.no_pages   = pages_left_reg == '0;

    assign pages = multi_reg ? (div_quo[12:0] + 13'd1)
                             : ((len_reg == '0) ? 13'd0 : 13'd1);

    assign product = 33'(frame_reg) * 33'(ps_eff);

    always_comb begin
        if (first_portion_reg) begin
            room = (ps_eff > {1'b0, start_offset_reg}) ? ps_eff - {1'b0, start_offset_reg}
                                                       : 17'd0;
            phys = prod_reg + {16'b0, start_offset_reg};
        end else begin
            room = ps_eff;
            phys = prod_reg;
        end
        plen_wide = (room < {4'b0, bytes_left_reg}) ? room : {4'b0, bytes_left_reg};
        plen      = plen_wide[12:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_size_reg     <= 17'd32;
            page_limit_reg    <= 16'd64;
            start_offset_reg  <= '0;
            bytes_left_reg    <= '0;
            data_base_reg     <= '0;
            pages_left_reg    <= '0;
            first_portion_reg <= 1'b1;
        end else begin
            if (cfg_write_en) begin
                unique case (cfg_index)
                    CFG_PAGE_SIZE:  page_size_reg  <= cfg_data;
                    CFG_PAGE_LIMIT: page_limit_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (cmd.emit_start) begin
                start_offset_reg  <= off_reg;
                bytes_left_reg    <= len_reg;
                data_base_reg     <= '0;
                pages_left_reg    <= pages;
                first_portion_reg <= 1'b1;
            end else if (cmd.emit_err) begin
                start_offset_reg  <= '0;
                bytes_left_reg    <= '0;
                data_base_reg     <= '0;
                pages_left_reg    <= '0;
                first_portion_reg <= 1'b1;
            end else if (cmd.emit_portion) begin
                data_base_reg     <= data_base_reg + plen;
                bytes_left_reg    <= bytes_left_reg - plen;
                pages_left_reg    <= pages_left_reg - 13'd1;
                first_portion_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            addr_reg  <= s_logical_address;
            len_reg   <= len_next;
            frame_reg <= s_frame_number;
        end
        if (cmd.save_start) begin
            page_reg  <= div_quo[15:0];
            off_reg   <= div_rem[15:0];
            multi_reg <= status.multi_page;
        end
        if (cmd.mul) begin
            prod_reg <= product[31:0];
        end
        if (cmd.emit_start) begin
            kind_reg           <= KIND_START;
            first_page_reg     <= page_reg;
            pages_needed_reg   <= pages;
            portion_base_reg   <= '0;
            portion_length_reg <= '0;
            phys_reg           <= '0;
            last_reg           <= 1'b0;
        end else if (cmd.emit_err) begin
            kind_reg           <= KIND_ERROR;
            first_page_reg     <= '0;
            pages_needed_reg   <= '0;
            portion_base_reg   <= '0;
            portion_length_reg <= '0;
            phys_reg           <= '0;
            last_reg           <= 1'b0;
        end else if (cmd.emit_portion) begin
            kind_reg           <= KIND_PORTION;
            first_page_reg     <= '0;
            pages_needed_reg   <= '0;
            portion_base_reg   <= data_base_reg;
            portion_length_reg <= plen;
            phys_reg           <= phys;
            last_reg           <= pages_left_reg == 13'd1;
        end
    end

    assign m_kind             = kind_reg;
    assign m_first_page       = first_page_reg;
    assign m_pages_needed     = pages_needed_reg;
    assign m_portion_base     = portion_base_reg;
    assign m_portion_length   = portion_length_reg;
    assign m_physical_address = phys_reg;
    assign m_last             = last_reg;

endmodule
`default_nettype wire

// File: design/pcas_ctrl.sv
`default_nettype none
module pcas_ctrl
    import pcas_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic         s_command,
    output logic              m_valid,
    input  wire logic         m_ready,
    output pcas_cmd_t         cmd,
    input  wire pcas_status_t status
);

    pcas_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;
    logic        emit;

    assign out_free = !out_valid_reg || m_ready;
    assign emit     = cmd.emit_start || cmd.emit_err || cmd.emit_portion;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    if (s_command == CMD_START) begin
                        state_next = ST_DIV_ADDR;
                    end else if (!status.no_pages) begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_DIV_ADDR: begin
                cmd.div_start = 1'b1;
                state_next    = ST_WAIT_ADDR;
            end
            ST_WAIT_ADDR: begin
                if (!status.div_busy) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.save_start = 1'b1;
                if (status.addr_err) begin
                    state_next = ST_EMIT_ERR;
                end else if (status.multi_page) begin
                    cmd.div_start = 1'b1;
                    cmd.div_len   = 1'b1;
                    state_next    = ST_WAIT_LEN;
                end else begin
                    state_next = ST_EMIT_START;
                end
            end
            ST_WAIT_LEN: begin
                if (!status.div_busy) begin
                    state_next = ST_EMIT_START;
                end
            end
            ST_EMIT_START: begin
                if (out_free) begin
                    cmd.emit_start = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_EMIT_ERR: begin
                if (out_free) begin
                    cmd.emit_err = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_EMIT_PORTION;
            end
            ST_EMIT_PORTION: begin
                if (out_free) begin
                    cmd.emit_portion = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    assign m_valid = out_valid_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !emit)
        else $error("result overwritten before transfer");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> status.div_busy)
        else $error("divider did not start");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK || state_reg == ST_EMIT_START) |-> !status.div_busy)
        else $error("division result used while divider busy");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_command == CMD_FRAME && status.no_pages)
        |=> (state_reg == ST_IDLE && !$rose(m_valid)))
        else $error("frame without pending access produced a result");

endmodule
`default_nettype wire

// File: design/page_crossing_access_splitter_core.sv
// Paged access splitter. A start transfer (command 0) divides the logical address by
// the page size in a shared 24-step restoring divider, one quotient bit per cycle;
// the same divider runs a second pass to count pages when the access crosses a page.
// A frame transfer (command 1) registers the frame times page size product, then does
// the offset add and result load. Frames with no access pending are dropped without a
// result. Results sit in an output register, so the next input is taken while a result
// still waits; a further result stalls until the waiting one is transferred.
// Configuration writes (index 0 page size, index 1 page limit) take effect at once and
// belong in idle time.
`default_nettype none
module page_crossing_access_splitter_core
    import pcas_pkg::*;
#(
    parameter int MAX_ACCESS_BYTES = 4096
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_write_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_command,
    input  wire logic [23:0]           s_logical_address,
    input  wire logic [12:0]           s_access_length,
    input  wire logic [15:0]           s_frame_number,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [1:0]                 m_kind,
    output logic [15:0]                m_first_page,
    output logic [12:0]                m_pages_needed,
    output logic [12:0]                m_portion_base,
    output logic [12:0]                m_portion_length,
    output logic [31:0]                m_physical_address,
    output logic                       m_last
);

    pcas_cmd_t    cmd;
    pcas_status_t status;

    pcas_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .status    (status)
    );

    pcas_datapath #(
        .MAX_ACCESS_BYTES (MAX_ACCESS_BYTES)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .cfg_write_en       (cfg_write_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_logical_address  (s_logical_address),
        .s_access_length    (s_access_length),
        .s_frame_number     (s_frame_number),
        .m_kind             (m_kind),
        .m_first_page       (m_first_page),
        .m_pages_needed     (m_pages_needed),
        .m_portion_base     (m_portion_base),
        .m_portion_length   (m_portion_length),
        .m_physical_address (m_physical_address),
        .m_last             (m_last)
    );

endmodule
`default_nettype wire
